// File: rtl/gaf_pkg.sv
// Shared types and constants of the grid alignment fitness scorer.
`timescale 1ns / 1ps
package gaf_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned DiffW     = 17;
  localparam int unsigned DimW      = 13;
  localparam int unsigned ScoreW    = 40;
  localparam int unsigned SeenW     = 11;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;

  localparam logic [CfgIdxW-1:0] RegOriginX    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOriginY    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDirX       = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDirY       = 3'd3;
  localparam logic [CfgIdxW-1:0] RegInvSpacing = 3'd4;
  localparam logic [CfgIdxW-1:0] RegImgWidth   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegImgHeight  = 3'd6;

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic signed [CoordW-1:0] dir_x;
    logic signed [CoordW-1:0] dir_y;
    logic [CoordW-1:0]        inv_spacing;
    logic [DimW-1:0]          image_width;
    logic [DimW-1:0]          image_height;
  } cfg_t;

  typedef struct packed {
    logic signed [DiffW-1:0] ex;
    logic signed [DiffW-1:0] ey;
    logic                    last;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/gaf_front.sv
// Front end: takes point requests and offsets them by the grid origin.
`timescale 1ns / 1ps
module gaf_front
  import gaf_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic                     last_point_i,
  input  cfg_t                     cfg_i,
  input  q_status_t                q_status_i,
  output logic                     in_ready_o,
  output logic                     push_o,
  output q_item_t                  item_o
);

  assign in_ready_o = !q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  always_comb begin
    item_o.ex   = DiffW'(point_x_i) - DiffW'(cfg_i.origin_x);
    item_o.ey   = DiffW'(point_y_i) - DiffW'(cfg_i.origin_y);
    item_o.last = last_point_i;
  end

  // A push is never offered while the queue is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_status_i.full)
    else $error("push while queue full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> in_ready_o)
    else $error("push without ready");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status_i.full |-> !push_o)
    else $error("full queue accepted a request");

endmodule

// File: rtl/gaf_queue.sv
// Small FIFO between the front end and the scoring pipeline.
`timescale 1ns / 1ps
module gaf_queue
  import gaf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  q_item_t   item_i,
  input  logic      pop_i,
  output q_item_t   item_o,
  output q_status_t status_o
);

  q_item_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wptr_q, wptr_d;
  logic [QueuePtrW-1:0]   rptr_q, rptr_d;
  logic [QueuePtrW:0]     cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign status_o.full  = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign item_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QueuePtrW+1)'(QueueDepth))
    else $error("queue fill count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue fill count missed a push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wptr_q - rptr_q) == cnt_q[QueuePtrW-1:0])
    else $error("queue pointers disagree with fill count");

endmodule

// File: rtl/gaf_back.sv
// Scoring pipeline: rotate, scale, fold, and accumulate the fitness weight.
`timescale 1ns / 1ps
module gaf_back
  import gaf_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  q_item_t           item_i,
  input  q_status_t         q_status_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ScoreW-1:0] score_o,
  output logic [SeenW-1:0]  points_seen_o
);

  localparam int unsigned CntW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned ExtW   = (CntW > SeenW) ? CntW : SeenW;
  localparam int unsigned FracW  = 34;
  localparam int unsigned ProdW  = 34;
  localparam int unsigned AreaW  = 2 * DimW;
  localparam int unsigned Inv2W  = 2 * CoordW;
  localparam int unsigned ExpW   = AreaW + Inv2W;
  localparam int unsigned DW     = ExpW + 1;
  localparam int unsigned TermW  = DW - 16 + 1;
  localparam int unsigned ItemW  = TermW + 1;
  localparam int unsigned AccW   = ItemW + 1;
  localparam logic [ScoreW-1:0] ScoreMax = '1;

  function automatic logic [16:0] frac_term(input logic [FracW-1:0] f);
    logic [FracW-1:0] d;
    logic [FracW:0]   r;
    begin
      d = (f <= {1'b1, {(FracW-1){1'b0}}}) ? f : (~f + 1'b1);
      r = {1'b0, d} + (FracW+1)'(1 << 17);
      frac_term = r[FracW:18];
    end
  endfunction

  logic en;
  assign en    = !(out_valid_o && !out_ready_i);
  assign pop_o = en && !q_status_i.empty;

  // Expected point count, rebuilt continuously from the configuration.
  logic [AreaW-1:0] area_q;
  logic [Inv2W-1:0] inv2_q;
  logic [ExpW-1:0]  exp_q;

  always_ff @(posedge clk_i) begin
    area_q <= AreaW'(cfg_i.image_width) * AreaW'(cfg_i.image_height);
    inv2_q <= Inv2W'(cfg_i.inv_spacing) * Inv2W'(cfg_i.inv_spacing);
    exp_q  <= ExpW'(area_q) * ExpW'(inv2_q);
  end

  // Stage 1: rotation products.
  logic signed [DiffW-1:0] cos_s, sin_s;
  logic signed [ProdW-1:0] p_cx_q, p_sy_q, p_sx_q, p_cy_q;
  logic                    v1_q, last1_q;

  always_comb begin
    cos_s = DiffW'(cfg_i.dir_y);
    sin_s = cfg_i.dir_x[CoordW-1] ? -DiffW'(cfg_i.dir_x) : DiffW'(cfg_i.dir_x);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      p_cx_q  <= ProdW'(cos_s) * ProdW'(item_i.ex);
      p_sy_q  <= ProdW'(sin_s) * ProdW'(item_i.ey);
      p_sx_q  <= ProdW'(sin_s) * ProdW'(item_i.ex);
      p_cy_q  <= ProdW'(cos_s) * ProdW'(item_i.ey);
      last1_q <= item_i.last;
    end
  end

  // Stage 2: combine and scale; only the fractional part is kept.
  logic [ProdW:0]       rx, ry;
  logic [FracW+15:0]    mx, my;
  logic [FracW-1:0]     fx_q, fy_q;
  logic                 v2_q, last2_q;

  always_comb begin
    rx = (ProdW+1)'(p_cx_q) - (ProdW+1)'(p_sy_q);
    ry = (ProdW+1)'(p_sx_q) + (ProdW+1)'(p_cy_q);
    mx = (FracW+16)'(rx[FracW-1:0]) * (FracW+16)'(cfg_i.inv_spacing);
    my = (FracW+16)'(ry[FracW-1:0]) * (FracW+16)'(cfg_i.inv_spacing);
  end

  always_ff @(posedge clk_i) begin
    if (en && v1_q) begin
      fx_q    <= mx[FracW-1:0];
      fy_q    <= my[FracW-1:0];
      last2_q <= last1_q;
    end
  end

  // Stage 3: distance terms, point count and count mismatch.
  logic [CntW-1:0] cnt_q, cnt_next, cnt3_q;
  logic [DW-1:0]   seen, expd, diff_q;
  logic [17:0]     tsum3_q;
  logic            v3_q, last3_q;

  always_comb begin
    cnt_next = (cnt_q < CntW'(MAX_POINTS)) ? cnt_q + 1'b1 : cnt_q;
    seen     = DW'(cnt_next) << 32;
    expd     = DW'(exp_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (en && v2_q) begin
      cnt_q <= last2_q ? '0 : cnt_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && v2_q) begin
      tsum3_q <= 18'(frac_term(fx_q)) + 18'(frac_term(fy_q));
      diff_q  <= (expd >= seen) ? expd - seen : seen - expd;
      cnt3_q  <= cnt_next;
      last3_q <= last2_q;
    end
  end

  // Stage 4: rounded mismatch term joins the distance terms on the last point.
  logic [TermW-1:0] term_f;
  logic [ItemW-1:0] item4_q;
  logic [CntW-1:0]  cnt4_q;
  logic             v4_q, last4_q;

  assign term_f = TermW'(diff_q[DW-1:16]) + TermW'(diff_q[15]);

  always_ff @(posedge clk_i) begin
    if (en && v3_q) begin
      item4_q <= ItemW'(tsum3_q) + (last3_q ? ItemW'(term_f) : '0);
      cnt4_q  <= cnt3_q;
      last4_q <= last3_q;
    end
  end

  // Stage 5: saturating accumulation and result register.
  logic [ScoreW-1:0] acc_q;
  logic [AccW-1:0]   acc_sum;
  logic [ScoreW-1:0] acc_sat;
  logic [ExtW-1:0]   cnt_ext;
  logic              out_valid_q;

  always_comb begin
    acc_sum = AccW'(acc_q) + AccW'(item4_q);
    acc_sat = (acc_sum >= AccW'(ScoreMax)) ? ScoreMax : acc_sum[ScoreW-1:0];
    cnt_ext = ExtW'(cnt4_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) begin
        v1_q <= pop_o;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        if (v4_q) begin
          acc_q <= last4_q ? '0 : acc_sat;
        end
      end
      if (en && v4_q && last4_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && v4_q && last4_q) begin
      score_o       <= acc_sat;
      points_seen_o <= cnt_ext[SeenW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(acc_q))
    else $error("accumulator moved while the pipeline was stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v4_q && last4_q) |=> (acc_q == '0) && (cnt_q == '0 || v3_q || v4_q))
    else $error("state not cleared after the last point");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(v4_q && last4_q))
    else $error("result appeared without a last point");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_POINTS))
    else $error("point count exceeded its limit");

endmodule

// File: rtl/grid_alignment_fitness_top.sv
// Top level of the grid alignment fitness scorer.
//
// Point requests arrive on the s_axis channel: tdata carries point_x and
// point_y, and tlast marks the final point of a set. For every set the block
// sends one result request on the m_axis channel with the saturated score
// and the number of points seen. Points that are not last produce nothing.
// Configuration registers are written through the cfg port; writes take
// effect at once. The user must make them only while no set is in progress;
// the block itself does not enforce this. A point is accepted whenever the
// four-entry input queue has room, so the block takes one point per cycle
// while the output is not stalled. The pace is set by the saturating add in
// the accumulator. When the receiver stalls, the scoring pipeline holds and
// the queue fills, after which s_axis_tready drops. Reset clears the queue,
// the pipeline, the accumulated score and count, and loads the register
// defaults.
`timescale 1ns / 1ps
module grid_alignment_fitness_top
  import gaf_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,  // point_x [15:0], point_y [31:16]
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [55:0]         m_axis_tdata   // score [39:0], points_seen [50:40], zeros
);

  cfg_t      cfg_q;
  q_item_t   push_item, head_item;
  q_status_t q_status;
  logic      push, pop;
  logic [ScoreW-1:0] score;
  logic [SeenW-1:0]  points_seen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x     <= '0;
      cfg_q.origin_y     <= '0;
      cfg_q.dir_x        <= '0;
      cfg_q.dir_y        <= 16'sd16384;
      cfg_q.inv_spacing  <= 16'd65535;
      cfg_q.image_width  <= 13'd640;
      cfg_q.image_height <= 13'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegOriginX:    cfg_q.origin_x     <= cfg_data_i;
        RegOriginY:    cfg_q.origin_y     <= cfg_data_i;
        RegDirX:       cfg_q.dir_x        <= cfg_data_i;
        RegDirY:       cfg_q.dir_y        <= cfg_data_i;
        RegInvSpacing: cfg_q.inv_spacing  <= cfg_data_i;
        RegImgWidth:   cfg_q.image_width  <= cfg_data_i[DimW-1:0];
        RegImgHeight:  cfg_q.image_height <= cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  gaf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .point_x_i    (s_axis_tdata[15:0]),
    .point_y_i    (s_axis_tdata[31:16]),
    .last_point_i (s_axis_tlast),
    .cfg_i        (cfg_q),
    .q_status_i   (q_status),
    .in_ready_o   (s_axis_tready),
    .push_o       (push),
    .item_o       (push_item)
  );

  gaf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .item_o   (head_item),
    .status_o (q_status)
  );

  gaf_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_i        (head_item),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .score_o       (score),
    .points_seen_o (points_seen)
  );

  assign m_axis_tdata = {5'b0, points_seen, score};

endmodule

// File: tb/grid_alignment_fitness_top_tb.sv
// Self-checking testbench that scores point sets against a built-in grid fitness predictor.
`timescale 1ns / 1ps
module grid_alignment_fitness_top_tb;
  import gaf_pkg::*;

  localparam int unsigned MaxPoints  = 1024;
  localparam int unsigned CycleLimit = 500000;
  localparam logic [63:0] ScoreMax   = (64'd1 << ScoreW) - 64'd1;
  localparam logic [63:0] FracOne    = 64'd1 << 34;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [SeenW-1:0]  seen;
  } fit_result_t;

  typedef enum logic [1:0] {ReadyAlways, ReadyCoin, ReadySparse, ReadyBursty} ready_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata;  // point_x [15:0], point_y [31:16]
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [55:0]         m_axis_tdata;  // score [39:0], points_seen [50:40], zeros

  logic signed [15:0] org_x = 16'sd0;
  logic signed [15:0] org_y = 16'sd0;
  logic signed [15:0] dir_x = 16'sd0;
  logic signed [15:0] dir_y = 16'sd16384;
  logic [15:0]        inv_sp = 16'd65535;
  logic [12:0]        img_w = 13'd640;
  logic [12:0]        img_h = 13'd480;

  logic [ScoreW-1:0] fit_sum = '0;
  int unsigned       fit_count = 0;
  fit_result_t       fit_expected[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  ready_mode_e ready_mode = ReadyAlways;
  int unsigned ready_left = 0;
  logic [31:0] ready_tick = '0;

  grid_alignment_fitness_top #(
    .MAX_POINTS(MaxPoints)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("grid_alignment_fitness_top_tb: errors");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_left = $urandom_range(16, 160);
    end
    ready_left--;
    ready_tick++;
    case (ready_mode)
      ReadyAlways: m_axis_tready <= 1'b1;
      ReadyCoin:   m_axis_tready <= 1'($urandom_range(0, 1));
      ReadySparse: m_axis_tready <= (ready_tick % 5 == 0);
      default:     m_axis_tready <= ready_tick[3];
    endcase
  end

  function automatic logic [ScoreW-1:0] sat_add(input logic [ScoreW-1:0] acc,
                                                input logic [63:0] term);
    logic [63:0] total;
    total = 64'(acc) + term;
    return (total >= ScoreMax) ? ScoreMax[ScoreW-1:0] : total[ScoreW-1:0];
  endfunction

  function automatic logic [63:0] offgrid_term(input logic [63:0] scaled);
    logic [63:0] frac;
    logic [63:0] distance;
    frac = scaled & (FracOne - 64'd1);
    distance = (frac <= FracOne - frac) ? frac : FracOne - frac;
    return (distance + (64'd1 << 17)) >> 18;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic score_point(input logic [15:0] px, input logic [15:0] py, input logic last);
    longint      ex, ey, cos_q, sin_q, inv, rot_x, rot_y;
    logic [63:0] grid_pts, seen_pts, diff, area_term;
    fit_result_t res;
    ex    = longint'($signed(px)) - longint'(org_x);
    ey    = longint'($signed(py)) - longint'(org_y);
    cos_q = longint'(dir_y);
    sin_q = longint'(dir_x);
    if (sin_q < 0) sin_q = -sin_q;
    inv   = longint'(inv_sp);
    rot_x = cos_q * ex - sin_q * ey;
    rot_y = sin_q * ex + cos_q * ey;
    fit_sum = sat_add(fit_sum, offgrid_term(64'(rot_x * inv)));
    fit_sum = sat_add(fit_sum, offgrid_term(64'(rot_y * inv)));
    if (fit_count < MaxPoints) fit_count++;
    if (last) begin
      grid_pts  = 64'(img_w) * 64'(img_h) * 64'(inv_sp) * 64'(inv_sp);
      seen_pts  = 64'(fit_count) << 32;
      diff      = (grid_pts >= seen_pts) ? grid_pts - seen_pts : seen_pts - grid_pts;
      area_term = (diff >> 16) + ((diff >> 15) & 64'd1);
      fit_sum   = sat_add(fit_sum, area_term);
      res.score = fit_sum;
      res.seen  = fit_count[SeenW-1:0];
      fit_expected.push_back(res);
      fit_sum   = '0;
      fit_count = 0;
    end
  endtask

  task automatic check_result(input logic [ScoreW-1:0] score, input logic [SeenW-1:0] seen);
    fit_result_t want;
    if (fit_expected.size() == 0) begin
      report_mismatch($sformatf("unexpected result score %0d seen %0d", score, seen));
      return;
    end
    want = fit_expected.pop_front();
    if (score !== want.score)
      report_mismatch($sformatf("score %0d, want %0d", score, want.score));
    if (seen !== want.seen)
      report_mismatch($sformatf("points_seen %0d, want %0d", seen, want.seen));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      score_point(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      check_result(m_axis_tdata[ScoreW-1:0], m_axis_tdata[ScoreW+SeenW-1:ScoreW]);
  end

  task automatic send_point(input logic [15:0] px, input logic [15:0] py, input logic last);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {py, px};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  task automatic idle_points();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (fit_expected.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      RegOriginX:    org_x  = data;
      RegOriginY:    org_y  = data;
      RegDirX:       dir_x  = data;
      RegDirY:       dir_y  = data;
      RegInvSpacing: inv_sp = data;
      RegImgWidth:   img_w  = data[12:0];
      RegImgHeight:  img_h  = data[12:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] ox, input logic [15:0] oy, input logic [15:0] dx,
                            input logic [15:0] dy, input logic [15:0] inv,
                            input logic [12:0] w, input logic [12:0] h);
    write_reg(RegOriginX, ox);
    write_reg(RegOriginY, oy);
    write_reg(RegDirX, dx);
    write_reg(RegDirY, dy);
    write_reg(RegInvSpacing, inv);
    write_reg(RegImgWidth, {3'b000, w});
    write_reg(RegImgHeight, {3'b000, h});
  endtask

  task automatic run_set(input int unsigned len);
    logic [15:0] px, py;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        px = org_x + 16'($urandom_range(0, 511)) - 16'd256;
        py = org_y + 16'($urandom_range(0, 511)) - 16'd256;
      end else begin
        px = 16'($urandom);
        py = 16'($urandom);
      end
      send_point(px, py, i == len - 1);
    end
  endtask

  task automatic test_reset_defaults();
    send_point(16'h0000, 16'h0000, 1'b1);
    send_point(16'h7FFF, 16'h8000, 1'b0);
    send_point(16'h8000, 16'h7FFF, 1'b0);
    send_point(16'h0010, 16'h0020, 1'b1);
    idle_points();
    wait_drained();
  endtask

  task automatic test_register_corners();
    set_config(16'h7FFF, 16'h8000, 16'hC000, 16'h0000, 16'h0000, 13'd0, 13'd0);
    send_point(16'h8000, 16'h8000, 1'b0);
    send_point(16'h7FFF, 16'h7FFF, 1'b0);
    send_point(16'h1234, 16'hFEDC, 1'b1);
    idle_points();
    wait_drained();
    set_config(16'h0000, 16'h0000, 16'h4000, 16'hC000, 16'h0001, 13'd4096, 13'd1);
    send_point(16'hFFFF, 16'h0001, 1'b0);
    send_point(16'h7FFF, 16'h8000, 1'b0);
    send_point(16'h0008, 16'hFFF8, 1'b1);
    idle_points();
    wait_drained();
  endtask

  task automatic test_score_saturation();
    set_config(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 13'h1FFF, 13'h1FFF);
    send_point(16'h7FFF, 16'h8000, 1'b0);
    send_point(16'h8000, 16'h7FFF, 1'b1);
    send_point(16'h0000, 16'h0000, 1'b1);
    idle_points();
    wait_drained();
  endtask

  task automatic test_count_saturation();
    set_config(16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'd4096, 13'd64, 13'd48);
    run_set(MaxPoints + 6);
    run_set(3);
    idle_points();
    wait_drained();
  endtask

  task automatic random_config(input bit wide);
    int          dir_a, dir_b;
    logic [15:0] inv;
    logic [12:0] w, h;
    if (wide) begin
      dir_a = $urandom;
      dir_b = $urandom;
      inv   = 16'($urandom);
      w     = 13'($urandom);
      h     = 13'($urandom);
    end else begin
      dir_a = int'($urandom_range(0, 32768)) - 16384;
      dir_b = int'($urandom_range(0, 32768)) - 16384;
      inv   = 16'($urandom_range(1, 65535));
      w     = 13'($urandom_range(1, 4096));
      h     = 13'($urandom_range(1, 4096));
    end
    set_config(16'($urandom), 16'($urandom), 16'(dir_a), 16'(dir_b), inv, w, h);
  endtask

  task automatic test_random_sets();
    int unsigned sent, len;
    for (int phase = 0; phase < 8; phase++) begin
      random_config(phase % 4 == 3);
      sent = 0;
      while (sent < 16) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 12);
        run_set(len);
        sent += len;
      end
      idle_points();
      wait_drained();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_register_corners();
    test_score_saturation();
    test_count_saturation();
    test_random_sets();

    idle_points();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("grid_alignment_fitness_top_tb: clean");
    end else begin
      $display("grid_alignment_fitness_top_tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/gaf_pkg.sv
rtl/gaf_front.sv
rtl/gaf_queue.sv
rtl/gaf_back.sv
rtl/grid_alignment_fitness_top.sv
tb/grid_alignment_fitness_top_tb.sv
